>>> rtl/assert_macros.svh
// Assertion macros for the slot allocator RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, held off while reset is active
`define CHECK_CLK(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Clocked check that also holds during reset
`define CHECK_ALWAYS(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> rtl/gfl_pkg.sv
// Shared types and constants for the growing free-list slot allocator.
// No dependencies; the RTL modules refer to it by scoped names.
package gfl_pkg;

    // Command codes carried in the request item
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_NO_POOL   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_INITIAL_COUNT = 2'd0;
    localparam logic [1:0] REG_ITEM_BYTES    = 2'd1;
    localparam logic [1:0] REG_FIRST_GROW    = 2'd2;

    // Register reset values
    localparam logic [10:0] INITIAL_COUNT_RST = 11'd64;
    localparam logic [12:0] ITEM_BYTES_RST    = 13'd8;
    localparam logic [10:0] FIRST_GROW_RST    = 11'd40;

    // Allocation constants
    localparam int unsigned GROW_RESET     = 40;
    localparam logic [12:0] ALIGN_MASK     = 13'd7;
    localparam logic [12:0] MAX_ITEM_BYTES = 13'd4096;
    localparam logic [12:0] ITEM_SIZE_RST  = 13'd8;
    localparam logic [10:0] AVAIL_MAX      = 11'd2047;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] handle;
        logic       handle_valid;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [21:0] byte_offset;
        logic [10:0] avail_count;
        logic [10:0] total_count;
    } rsp_item_t;

    typedef struct packed {
        logic [10:0] initial_count;
        logic [12:0] item_bytes;
        logic [10:0] first_grow;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

>>> rtl/gfl_regs.sv
// APB-style configuration registers for the slot allocator.
// Depends on gfl_pkg for register indexes, reset values and the cfg_t type.
module gfl_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output gfl_pkg::cfg_t       cfg
);

    gfl_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes, decoded on the word index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_count <= gfl_pkg::INITIAL_COUNT_RST;
            cfg_reg.item_bytes    <= gfl_pkg::ITEM_BYTES_RST;
            cfg_reg.first_grow    <= gfl_pkg::FIRST_GROW_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                gfl_pkg::REG_INITIAL_COUNT: cfg_reg.initial_count <= pwdata[10:0];
                gfl_pkg::REG_ITEM_BYTES:    cfg_reg.item_bytes    <= pwdata[12:0];
                gfl_pkg::REG_FIRST_GROW:    cfg_reg.first_grow    <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[3:2])
            gfl_pkg::REG_INITIAL_COUNT: prdata = {21'd0, cfg_reg.initial_count};
            gfl_pkg::REG_ITEM_BYTES:    prdata = {19'd0, cfg_reg.item_bytes};
            gfl_pkg::REG_FIRST_GROW:    prdata = {21'd0, cfg_reg.first_grow};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/gfl_ctrl.sv
// Handshake controller for the slot allocator: two-state sequencer plus
// the result valid flag. Depends on gfl_pkg for state_t and dp_cmd_t.
module gfl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output gfl_pkg::dp_cmd_t   cmd
);

    gfl_pkg::state_t state_reg;
    gfl_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;

    assign rsp_valid = rsp_valid_reg;

    // State and result flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gfl_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state and commands; idle takes an item even while a result waits
    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            gfl_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = gfl_pkg::S_EXEC;
                end
            end
            gfl_pkg::S_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = gfl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gfl_pkg::S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

endmodule

>>> rtl/gfl_dp.sv
// Datapath of the slot allocator: pool counters, freed-slot stack memory,
// offset multiplier and result register. Depends on gfl_pkg.
module gfl_dp #(
    parameter int SLOTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gfl_pkg::dp_cmd_t    cmd,
    input  gfl_pkg::req_item_t  req,
    input  gfl_pkg::cfg_t       cfg,
    output gfl_pkg::rsp_item_t  rsp
);

    localparam int CW = $clog2(SLOTS + 1);          // counts 0..SLOTS
    localparam int AW = $clog2(SLOTS);              // stack index
    localparam int SW = (CW > 10) ? CW : 10;        // slot value
    localparam int PW = SW + 13;                    // offset product
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [CW:0]   SLOTS_W = (CW + 1)'(SLOTS);
    localparam int GROW_INIT = (gfl_pkg::GROW_RESET > SLOTS) ? SLOTS : gfl_pkg::GROW_RESET;

    // Freed-slot stack
    logic [9:0] stack_mem [SLOTS];
    logic [9:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic       wr_en;

    // Pool state
    logic [CW-1:0] depth_reg, depth_next;
    logic [CW-1:0] fresh_next_reg, fresh_next_next;
    logic [CW-1:0] floor_reg, floor_next;
    logic [CW-1:0] owned_reg, owned_next;
    logic [CW-1:0] grow_reg, grow_next;
    logic          started_reg, started_next;
    logic [12:0]   item_size_reg, item_size_next;

    gfl_pkg::req_item_t req_reg;
    gfl_pkg::rsp_item_t rsp_reg;

    // Working values
    logic [1:0]    status;
    logic          alloc_ok;
    logic [SW-1:0] slot_val;
    logic [PW-1:0] prod;
    logic [12:0]   bytes_lim;
    logic [CW:0]   grow_dbl;
    logic [CW-1:0] room;
    logic [CW:0]   avail_sum;
    logic [31:0]   avail_w;

    assign rd_addr = AW'(depth_reg - 1'b1);
    assign rsp     = rsp_reg;

    // Stack memory: registered read of the current top entry
    always_ff @(posedge clk)
    begin
        rd_data_reg <= stack_mem[rd_addr];
        if (wr_en)
        begin
            stack_mem[depth_reg[AW-1:0]] <= req_reg.handle;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
    end

    // Pool state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            fresh_next_reg <= '0;
            floor_reg      <= '0;
            owned_reg      <= '0;
            grow_reg       <= CW'(GROW_INIT);
            started_reg    <= 1'b0;
            item_size_reg  <= gfl_pkg::ITEM_SIZE_RST;
        end
        else if (cmd.commit)
        begin
            depth_reg      <= depth_next;
            fresh_next_reg <= fresh_next_next;
            floor_reg      <= floor_next;
            owned_reg      <= owned_next;
            grow_reg       <= grow_next;
            started_reg    <= started_next;
            item_size_reg  <= item_size_next;
        end
    end

    // Command evaluation
    always_comb
    begin
        depth_next      = depth_reg;
        fresh_next_next = fresh_next_reg;
        floor_next      = floor_reg;
        owned_next      = owned_reg;
        grow_next       = grow_reg;
        started_next    = started_reg;
        item_size_next  = item_size_reg;
        status          = gfl_pkg::ST_OK;
        alloc_ok        = 1'b0;
        slot_val        = '0;
        wr_en           = 1'b0;
        bytes_lim       = (cfg.item_bytes > gfl_pkg::MAX_ITEM_BYTES) ?
                          gfl_pkg::MAX_ITEM_BYTES : cfg.item_bytes;
        grow_dbl        = {grow_reg, 1'b0};
        room            = SLOTS_C - owned_reg;

        case (req_reg.mode)
            gfl_pkg::MODE_START:
            begin
                depth_next      = '0;
                fresh_next_next = '0;
                floor_next      = '0;
                owned_next      = '0;
                started_next    = 1'b0;
                if (cfg.initial_count == 11'd0 || cfg.item_bytes == 13'd0)
                begin
                    status = gfl_pkg::ST_NO_POOL;
                end
                else if (32'(cfg.initial_count) > 32'(SLOTS))
                begin
                    status = gfl_pkg::ST_NO_SPACE;
                end
                else
                begin
                    item_size_next  = (bytes_lim + gfl_pkg::ALIGN_MASK) & ~gfl_pkg::ALIGN_MASK;
                    grow_next       = (32'(cfg.first_grow) > 32'(SLOTS)) ?
                                      SLOTS_C : CW'(cfg.first_grow);
                    fresh_next_next = CW'(cfg.initial_count);
                    owned_next      = CW'(cfg.initial_count);
                    started_next    = 1'b1;
                end
            end
            gfl_pkg::MODE_ALLOC:
            begin
                if (!started_reg)
                begin
                    status = gfl_pkg::ST_NO_POOL;
                end
                else if (depth_reg != '0)
                begin
                    // pop the most recently freed slot
                    depth_next = depth_reg - 1'b1;
                    slot_val   = SW'(rd_data_reg);
                    alloc_ok   = 1'b1;
                end
                else if (fresh_next_reg != floor_reg)
                begin
                    fresh_next_next = fresh_next_reg - 1'b1;
                    slot_val        = SW'(fresh_next_next);
                    alloc_ok        = 1'b1;
                end
                else if (grow_reg == '0 || grow_reg > room)
                begin
                    status = gfl_pkg::ST_NO_SPACE;
                end
                else
                begin
                    // add a new chunk above all owned slots, hand out its top slot
                    floor_next      = owned_reg;
                    owned_next      = owned_reg + grow_reg;
                    fresh_next_next = owned_next - 1'b1;
                    grow_next       = (grow_dbl > SLOTS_W) ? SLOTS_C : grow_dbl[CW-1:0];
                    slot_val        = SW'(fresh_next_next);
                    alloc_ok        = 1'b1;
                end
            end
            gfl_pkg::MODE_FREE:
            begin
                if (!started_reg)
                begin
                    status = gfl_pkg::ST_NO_POOL;
                end
                else if (!req_reg.handle_valid)
                begin
                    status = gfl_pkg::ST_OK;
                end
                else if (depth_reg >= SLOTS_C)
                begin
                    status = gfl_pkg::ST_OVERFLOW;
                end
                else
                begin
                    wr_en      = cmd.commit;
                    depth_next = depth_reg + 1'b1;
                end
            end
            default: ;
        endcase

        avail_sum = (CW + 1)'(depth_next) + (CW + 1)'(fresh_next_next - floor_next);
        avail_w   = 32'(avail_sum);
    end

    assign prod = PW'(slot_val) * PW'(item_size_reg);

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.status      <= status;
            rsp_reg.slot        <= slot_val[9:0];
            rsp_reg.byte_offset <= alloc_ok ? 22'(prod) : 22'd0;
            rsp_reg.avail_count <= (avail_w > 32'(gfl_pkg::AVAIL_MAX)) ?
                                   gfl_pkg::AVAIL_MAX : 11'(avail_w);
            rsp_reg.total_count <= 11'(owned_next);
        end
    end

endmodule

>>> rtl/growing_free_list_slot_allocator_unit.sv
// Top level of the growing free-list slot allocator.
// Depends on gfl_pkg, gfl_regs, gfl_ctrl, gfl_dp and assert_macros.svh.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------
//   req     | in        | req_valid / req_ready | gfl_pkg::req_item_t
//   rsp     | out       | rsp_valid / rsp_ready | gfl_pkg::rsp_item_t
//   apb     | in        | psel, penable, pready | paddr, pwdata / prdata
//
// Each item is accepted in the idle state while the stack memory reads
// its top entry; the exec state then updates the pool and loads the result
// register. A new item is taken while a finished result waits; the update
// stalls until the result register is free. Reset clears the pool at once.
`include "assert_macros.svh"

module growing_free_list_slot_allocator_unit #(
    parameter int SLOTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  gfl_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output gfl_pkg::rsp_item_t  rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    gfl_pkg::cfg_t    cfg;
    gfl_pkg::dp_cmd_t cmd;

    gfl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    gfl_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .cfg   (cfg),
        .rsp   (rsp)
    );

    // Only one item in flight: after a capture the block is not ready in the next cycle
    `CHECK_CLK(a_one_in_flight, clk, rst_n, cmd.capture |=> !req_ready, "second item taken early")
    // The update never overwrites a result still waiting
    `CHECK_CLK(a_commit_free, clk, rst_n, cmd.commit |-> (!rsp_valid || rsp_ready), "result overwritten")
    // Every update presents a result in the following cycle
    `CHECK_CLK(a_commit_shows, clk, rst_n, cmd.commit |=> rsp_valid, "result lost")
    // Capture and update never coincide
    `CHECK_ALWAYS(a_cmd_excl, clk, !(cmd.capture && cmd.commit), "capture during update")

endmodule

>>> tb/sv/gfl_pool_checker.sv
// Checker for the slot allocator: mirrors the pool and its registers, predicts
// every result and compares each accepted result field by field.
// Depends on gfl_pkg; instantiated beside the block by the testbench top.
module gfl_pool_checker #(
    parameter int SLOTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  gfl_pkg::req_item_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  gfl_pkg::rsp_item_t rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 mismatches,
    output int                 pending,
    output int                 checked,
    output logic [3:0]         status_seen
);
    import gfl_pkg::*;

    // Register copies
    logic [10:0] cfg_initial;
    logic [12:0] cfg_bytes;
    logic [10:0] cfg_grow;

    // Pool mirror; fresh slots still unused are fresh_lo .. fresh_hi-1
    logic [9:0]  freed_slots [SLOTS];
    int unsigned stack_top;
    int unsigned fresh_hi;
    int unsigned fresh_lo;
    int unsigned owned;
    int unsigned grow_next;
    int unsigned slot_bytes;
    bit          pool_live;

    rsp_item_t   expected_results [$];

    // Advance the pool mirror by one item and return the result it causes
    function automatic rsp_item_t pool_outcome(input req_item_t cmd);
        rsp_item_t   res;
        logic [1:0]  code;
        int unsigned pick;
        int unsigned clipped;
        int unsigned avail;
        bit          granted;
        res = '0;
        code = ST_OK;
        pick = 0;
        granted = 1'b0;
        case (cmd.mode)
            MODE_START:
            begin
                // a start always drops the old pool, even when it fails
                stack_top = 0;
                fresh_hi = 0;
                fresh_lo = 0;
                owned = 0;
                pool_live = 1'b0;
                if (cfg_initial == 0 || cfg_bytes == 0)
                    code = ST_NO_POOL;
                else if (cfg_initial > SLOTS)
                    code = ST_NO_SPACE;
                else
                begin
                    clipped = 32'((cfg_bytes > MAX_ITEM_BYTES) ? MAX_ITEM_BYTES : cfg_bytes);
                    slot_bytes = ((clipped + 7) / 8) * 8;
                    grow_next = (cfg_grow > SLOTS) ? SLOTS : 32'(cfg_grow);
                    fresh_hi = 32'(cfg_initial);
                    owned = 32'(cfg_initial);
                    pool_live = 1'b1;
                end
            end
            MODE_ALLOC:
            begin
                if (!pool_live)
                    code = ST_NO_POOL;
                else if (stack_top > 0)
                begin
                    stack_top--;
                    pick = 32'(freed_slots[stack_top]);
                    granted = 1'b1;
                end
                else
                begin
                    // no fresh slot left: add a chunk above everything owned
                    if (fresh_hi == fresh_lo)
                    begin
                        if (grow_next == 0 || grow_next > SLOTS - owned)
                            code = ST_NO_SPACE;
                        else
                        begin
                            fresh_lo = owned;
                            fresh_hi = owned + grow_next;
                            owned = owned + grow_next;
                            grow_next = (grow_next * 2 > SLOTS) ? SLOTS : grow_next * 2;
                        end
                    end
                    if (code == ST_OK)
                    begin
                        fresh_hi--;
                        pick = fresh_hi;
                        granted = 1'b1;
                    end
                end
            end
            MODE_FREE:
            begin
                if (!pool_live)
                    code = ST_NO_POOL;
                else if (cmd.handle_valid)
                begin
                    if (stack_top >= SLOTS)
                        code = ST_OVERFLOW;
                    else
                    begin
                        freed_slots[stack_top] = cmd.handle;
                        stack_top++;
                    end
                end
            end
            default: ;
        endcase
        avail = stack_top + fresh_hi - fresh_lo;
        res.status = code;
        if (granted)
        begin
            res.slot = pick[9:0];
            res.byte_offset = 22'(pick * slot_bytes);
        end
        res.avail_count = (avail > AVAIL_MAX) ? AVAIL_MAX : avail[10:0];
        res.total_count = owned[10:0];
        return res;
    endfunction

    task automatic note_field(input string tag, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         checked, tag, want, got);
            mismatches++;
        end
    endtask

    // Sample all channels at the clock edge, before the drivers update
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_item_t want;
        if (!rst_n)
        begin
            cfg_initial = INITIAL_COUNT_RST;
            cfg_bytes = ITEM_BYTES_RST;
            cfg_grow = FIRST_GROW_RST;
            stack_top = 0;
            fresh_hi = 0;
            fresh_lo = 0;
            owned = 0;
            grow_next = GROW_RESET;
            slot_bytes = 32'(ITEM_SIZE_RST);
            pool_live = 1'b0;
            expected_results.delete();
            pending = 0;
            status_seen = '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_INITIAL_COUNT: cfg_initial = pwdata[10:0];
                    REG_ITEM_BYTES:    cfg_bytes = pwdata[12:0];
                    REG_FIRST_GROW:    cfg_grow = pwdata[10:0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                expected_results.push_back(pool_outcome(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d arrived with nothing expected (status %0d)",
                                 checked, rsp.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    note_field("status", 32'(want.status), 32'(rsp.status));
                    note_field("slot", 32'(want.slot), 32'(rsp.slot));
                    note_field("byte_offset", 32'(want.byte_offset),
                               32'(rsp.byte_offset));
                    note_field("avail_count", 32'(want.avail_count),
                               32'(rsp.avail_count));
                    note_field("total_count", 32'(want.total_count),
                               32'(rsp.total_count));
                    status_seen[rsp.status] = 1'b1;
                end
                checked++;
            end
            pending = expected_results.size();
        end
    end

endmodule

>>> tb/sv/growing_free_list_slot_allocator_unit_tb.sv
// Testbench top for the growing free-list slot allocator: clock, reset,
// register setup and command stimulus; gfl_pool_checker does the checking.
// Depends on gfl_pkg, gfl_pool_checker and the allocator RTL.
module growing_free_list_slot_allocator_unit_tb;
    import gfl_pkg::*;

    localparam int         SLOTS         = 1024;
    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         LONG_HOLD     = 150;
    localparam int         RAND_PHASES   = 4;
    localparam int         RAND_ITEMS    = 44;
    localparam int         FLOOD_FREES   = SLOTS + 6;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_item_t   req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_item_t   rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          checked;
    logic [3:0]  status_seen;

    int          cycles = 0;
    int          cmds_sent;
    int          pool_settings;
    int          holds_asked;
    int          holds_done;
    bit          sender_idle;
    bit          receiver_idle;

    growing_free_list_slot_allocator_unit #(
        .SLOTS (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    gfl_pool_checker #(
        .SLOTS (SLOTS)
    ) pool_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .status_seen (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic req_item_t make_cmd(input logic [1:0] mode,
                                           input logic [9:0] handle,
                                           input logic hv);
        req_item_t it;
        it.mode = mode;
        it.handle = handle;
        it.handle_valid = hv;
        return it;
    endfunction

    // Random command: mostly allocate/free, a few restarts and spare codes
    function automatic req_item_t pick_cmd(input int alloc_pct);
        int roll;
        logic [1:0] mode;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
            mode = MODE_ALLOC;
        else if (roll < alloc_pct + 2)
            mode = MODE_START;
        else if (roll < alloc_pct + 4)
            mode = MODE_SPARE;
        else
            mode = MODE_FREE;
        return make_cmd(mode, 10'($urandom_range(0, 1023)), $urandom_range(0, 9) != 0);
    endfunction

    // Slot count register value, with the out-of-range ends now and then
    function automatic logic [10:0] pick_count();
        int roll;
        roll = $urandom_range(0, 19);
        case (roll)
            0:       return 11'd0;
            1:       return 11'(SLOTS);
            2:       return 11'($urandom_range(SLOTS + 1, 2047));
            3:       return 11'($urandom_range(1, SLOTS));
            default: return 11'($urandom_range(1, 96));
        endcase
    endfunction

    function automatic logic [12:0] pick_bytes();
        int roll;
        roll = $urandom_range(0, 19);
        case (roll)
            0:       return 13'd0;
            1:       return 13'($urandom_range(MAX_ITEM_BYTES + 1, 8191));
            2:       return MAX_ITEM_BYTES;
            default: return 13'($urandom_range(1, MAX_ITEM_BYTES));
        endcase
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_cmd(input req_item_t it);
        int gap;
        gap = sender_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        cmds_sent++;
    endtask

    // Stop offering until every outstanding result is back, then let it drain
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_pool(input logic [10:0] count, input logic [12:0] bytes,
                            input logic [10:0] grow);
        settle();
        reg_write(REG_INITIAL_COUNT, 32'(count));
        reg_write(REG_ITEM_BYTES, 32'(bytes));
        reg_write(REG_FIRST_GROW, 32'(grow));
        pool_settings++;
    endtask

    // Result side: random stalls plus the occasional long hold-off
    initial
    begin : result_side
        int stall;
        rsp_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = receiver_idle ? $urandom_range(0, 17) : 0;
            if (holds_asked != holds_done)
            begin
                stall += LONG_HOLD;
                holds_done++;
            end
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int alloc_pct;
        cmds_sent = 0;
        pool_settings = 0;
        holds_asked = 0;
        holds_done = 0;
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: use before start, null and double free, pops
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_FREE, 10'd1023, 1'b1));
        send_cmd(make_cmd(MODE_SPARE, 10'd1023, 1'b1));
        send_cmd(make_cmd(MODE_START, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_FREE, 10'd1023, 1'b0));
        send_cmd(make_cmd(MODE_FREE, 10'd1023, 1'b1));
        send_cmd(make_cmd(MODE_FREE, 10'd1023, 1'b1));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b1));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b1));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b1));
        send_cmd(make_cmd(MODE_FREE, 10'd0, 1'b1));
        send_cmd(make_cmd(MODE_START, 10'd1023, 1'b1));

        // Bad starts: zero count, zero size, count beyond the pool
        set_pool(11'd0, 13'd8, 11'd40);
        send_cmd(make_cmd(MODE_START, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b0));
        set_pool(11'd16, 13'd0, 11'd40);
        send_cmd(make_cmd(MODE_START, 10'd0, 1'b0));
        set_pool(11'd2047, 13'd8, 11'd40);
        send_cmd(make_cmd(MODE_START, 10'd0, 1'b0));

        // Oversized item with zero growth
        set_pool(11'd1, 13'd8191, 11'd0);
        send_cmd(make_cmd(MODE_START, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b0));

        // Full pool at the largest item, highest offset
        set_pool(11'(SLOTS), MAX_ITEM_BYTES, 11'd2047);
        send_cmd(make_cmd(MODE_START, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b0));

        // Growth clipped to the pool size no longer fits
        set_pool(11'd1, 13'd1, 11'd2047);
        send_cmd(make_cmd(MODE_START, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b0));
        send_cmd(make_cmd(MODE_ALLOC, 10'd0, 1'b0));

        // Fill the freed stack past its depth while results are held back
        set_pool(11'(SLOTS), 13'd8, 11'(SLOTS));
        send_cmd(make_cmd(MODE_START, 10'd0, 1'b0));
        holds_asked++;
        for (int i = 0; i < FLOOD_FREES; i++)
            send_cmd(make_cmd(MODE_FREE, 10'($urandom_range(0, 1023)), 1'b1));
        send_cmd(make_cmd(MODE_FREE, 10'($urandom_range(0, 1023)), 1'b0));
        for (int i = 0; i < 12; i++)
            send_cmd(make_cmd(MODE_ALLOC, 10'($urandom_range(0, 1023)),
                              1'($urandom_range(0, 1))));

        // Random phases, each with its own settings and idle pattern
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_pool(pick_count(), pick_bytes(), pick_count());
            sender_idle = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            receiver_idle = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            alloc_pct = $urandom_range(45, 75);
            send_cmd(make_cmd(MODE_START, 10'($urandom_range(0, 1023)),
                              1'($urandom_range(0, 1))));
            for (int i = 0; i < RAND_ITEMS; i++)
            begin
                if (ph == 1 && i == RAND_ITEMS / 2)
                    settle();
                if (ph == 2 && i == 10)
                    holds_asked++;
                send_cmd(pick_cmd(alloc_pct));
            end
        end

        settle();
        $display("Sent %0d commands over %0d register settings; %0d results compared.",
                 cmds_sent, pool_settings, checked);
        $display("Status codes returned, one bit per code from overflow down to ok: %b",
                 status_seen);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
